### hdl/trc_pkg.sv
// Package for the thermal regulation controller.
// Holds the state, configuration and sample types, register indexes and constants.
// No dependencies.
`default_nettype none

package trc_pkg;

  // Working width for temperature compares: covers -40 .. 258 without wrap.
  localparam int TempW = 10;
  localparam int PeakW = 9;

  localparam logic signed [TempW-1:0] SensorBias = 10'sd40;
  localparam logic signed [TempW-1:0] FanMargin  = 10'sd3;

  // Configuration register indexes
  localparam logic [1:0] REG_TARGET     = 2'd0;
  localparam logic [1:0] REG_CRITICAL   = 2'd1;
  localparam logic [1:0] REG_COOLDOWN   = 2'd2;
  localparam logic [1:0] REG_HYSTERESIS = 2'd3;

  localparam logic [7:0] TargetReset     = 8'd125;
  localparam logic [7:0] CriticalReset   = 8'd180;
  localparam logic [6:0] CooldownReset   = 7'd50;
  localparam logic [3:0] HysteresisReset = 4'd10;
  localparam logic signed [PeakW-1:0] PeakReset = -9'sd40;

  typedef struct packed {
    logic [7:0] target_temp;
    logic [7:0] critical_temp;
    logic [6:0] cooldown_temp;
    logic [3:0] hysteresis_temp;
  } cfg_t;

  typedef struct packed {
    logic       fan1_failed;
    logic       heater_failed;
    logic       alarm_pending;
    logic [7:0] sensor_raw;
  } sample_t;

  typedef struct packed {
    logic                    critical_latch;
    logic                    cooldown_latch;
    logic                    heating_demand;
    logic signed [PeakW-1:0] max_seen;
    logic                    heater_pin;
    logic                    fan1_pin;
    logic                    fan2_pin;
  } ctl_state_t;

endpackage

`default_nettype wire

### hdl/trc_step.sv
// One regulation step: next controller state from current state, config and sample.
// Pure combinational. Depends on trc_pkg.
`default_nettype none

module trc_step (
  input  trc_pkg::ctl_state_t state,
  input  trc_pkg::cfg_t       cfg,
  input  trc_pkg::sample_t    sample,
  output trc_pkg::ctl_state_t state_next,
  output logic                alarm_ack
);
  import trc_pkg::*;

  logic signed [TempW-1:0] t;
  logic signed [TempW-1:0] tgt;
  logic signed [TempW-1:0] crit;
  logic signed [TempW-1:0] cool;
  logic signed [TempW-1:0] low;
  logic signed [TempW-1:0] peak_ext;

  assign t        = $signed({2'b00, sample.sensor_raw}) - SensorBias;
  assign tgt      = $signed({2'b00, cfg.target_temp});
  assign crit     = $signed({2'b00, cfg.critical_temp});
  assign cool     = $signed({3'b000, cfg.cooldown_temp});
  assign low      = tgt - $signed({6'b000000, cfg.hysteresis_temp});
  assign peak_ext = TempW'(state.max_seen);

  always_comb begin
    logic done;
    done      = 1'b0;
    alarm_ack = 1'b0;
    state_next = state;

    if (t > peak_ext) begin
      state_next.max_seen = t[PeakW-1:0];
    end

    // emergency cooling latch
    if (t > crit || state.critical_latch) begin
      if (!state.critical_latch) begin
        state_next.critical_latch = 1'b1;
        state_next.fan2_pin       = 1'b1;
        state_next.heater_pin     = 1'b0;
      end
      if (t < cool) begin
        state_next.critical_latch = 1'b0;
        state_next.fan2_pin       = 1'b0;
      end else begin
        done = 1'b1;
      end
    end

    if (!done) begin
      if (sample.alarm_pending) begin
        state_next.cooldown_latch = 1'b1;
      end
      // alarm cooldown
      if (state_next.cooldown_latch) begin
        if (t < cool) begin
          state_next.cooldown_latch = 1'b0;
          alarm_ack = 1'b1;
          if (t < low) begin
            state_next.heating_demand = 1'b1;
            state_next.fan1_pin       = 1'b0;
          end
          state_next.max_seen = t[PeakW-1:0];
        end else begin
          if (!sample.fan1_failed) begin
            state_next.fan1_pin = 1'b1;
          end
          state_next.heater_pin = 1'b0;
          done = 1'b1;
        end
      end
    end

    if (!done) begin
      // hysteresis thermostat
      if (t < low) begin
        state_next.heating_demand = 1'b1;
      end else if (t >= tgt) begin
        state_next.heating_demand = 1'b0;
      end
      if (state_next.heating_demand && !sample.heater_failed) begin
        state_next.heater_pin = 1'b1;
        state_next.fan1_pin   = 1'b0;
      end else begin
        state_next.heater_pin = 1'b0;
        state_next.fan1_pin   = (t > tgt + FanMargin) && !sample.fan1_failed;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/thermal_regulation_controller.sv
// Thermal regulation controller top level: stream ports, config registers,
// controller state that doubles as the result register. Depends on trc_pkg, trc_step.
`default_nettype none

//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       s_tdata: one sensor sample
//  m_*       out        m_tvalid / m_tready       m_tdata: pin levels, flags, peak
//  cfg_*     in         cfg_wen (no wait)         cfg_index, cfg_wdata
//
// One sample per cycle while the result slot can take it: the step logic runs from the
// s_tdata port to the state register, which is also what m_tdata shows.
// A sample is taken whenever the result slot is empty or being read out in
// the same cycle, so a stalled m_tready holds at most one result.
// rst (synchronous) restores the power-up thresholds, clears latches, pins and
// the result slot, and sets the peak to -40 C.

module thermal_regulation_controller (
  input  logic        clk,
  input  logic        rst,
  // sensor samples
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sensor_raw[7:0], alarm_pending, heater_failed,
                                 // fan1_failed, zero fill
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // heater_on, fan1_on, fan2_on, alarm_ack,
                                 // critical_flag, cooldown_flag, heating_flag,
                                 // peak_temp[8:0]
  // configuration writes
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import trc_pkg::*;

  cfg_t       cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  sample_t    sample;
  logic       ack;
  logic       ack_next;
  logic       take;

  assign sample   = sample_t'(s_tdata[10:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp     <= TargetReset;
      cfg.critical_temp   <= CriticalReset;
      cfg.cooldown_temp   <= CooldownReset;
      cfg.hysteresis_temp <= HysteresisReset;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TARGET:     cfg.target_temp     <= cfg_wdata;
        REG_CRITICAL:   cfg.critical_temp   <= cfg_wdata;
        REG_COOLDOWN:   cfg.cooldown_temp   <= cfg_wdata[6:0];
        REG_HYSTERESIS: cfg.hysteresis_temp <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  trc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .sample     (sample),
    .state_next (state_next),
    .alarm_ack  (ack_next)
  );

  // controller state; it is exactly the result of the last transfer taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state.critical_latch <= 1'b0;
      state.cooldown_latch <= 1'b0;
      state.heating_demand <= 1'b0;
      state.max_seen       <= PeakReset;
      state.heater_pin     <= 1'b0;
      state.fan1_pin       <= 1'b0;
      state.fan2_pin       <= 1'b0;
      ack                  <= 1'b0;
      m_tvalid             <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
        ack   <= ack_next;
      end
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {state.max_seen, state.heating_demand, state.cooldown_latch,
                    state.critical_latch, ack, state.fan2_pin, state.fan1_pin,
                    state.heater_pin};

`ifndef SYNTHESIS
  // emergency fan tracks the critical latch exactly
  a_fan2_crit: assert property (@(posedge clk) disable iff (rst)
    state.fan2_pin == state.critical_latch)
    else $error("fan 2 out of step with critical latch");

  // heater never runs during emergency cooling
  a_crit_heater: assert property (@(posedge clk) disable iff (rst)
    state.critical_latch |-> !state.heater_pin)
    else $error("heater on while critical latch set");

  // heater never runs during alarm cooldown
  a_cool_heater: assert property (@(posedge clk) disable iff (rst)
    state.cooldown_latch |-> !state.heater_pin)
    else $error("heater on during alarm cooldown");

  // an acknowledge means the cooldown latch just released
  a_ack_clear: assert property (@(posedge clk) disable iff (rst)
    ack |-> !state.cooldown_latch)
    else $error("alarm ack with cooldown still latched");

  // every sample taken leaves a result waiting
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("result lost after sample transfer");
`endif

endmodule

`default_nettype wire
